>>> src/crc8fr_pkg.sv
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Shared types and constants for the CRC-8 frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crc8fr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

    localparam logic [BYTE_W-1:0] START_CODE_RST = 8'd170;
    localparam logic [BYTE_W-1:0] ACK_CODE_RST   = 8'd6;
    localparam logic [BYTE_W-1:0] NAK_CODE_RST   = 8'd21;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAK   = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CMD    = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_LEN_HI = 3'd3,
        PH_DATA   = 3'd4,
        PH_CRC    = 3'd5
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        EV_ACK  = 3'd0,
        EV_NAK  = 3'd1,
        EV_DATA = 3'd2,
        EV_GOOD = 3'd3,
        EV_BAD  = 3'd4
    } t_event;

endpackage

`default_nettype wire

>>> src/crc8_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// crc8_frame_receiver_unit
// Byte-serial frame parser: ack/nak/start detection, header capture,
// streamed payload with position, CRC-8 check on the closing byte.
// ----------------------------------------------------------------------------
// The result beat of an accepted byte is registered for the next cycle.
// Throughput: one byte per cycle unless stalled; the parse state and the
// one-byte CRC step are combinational, the result register decouples output.
// Reset: synchronous active low; returns to idle, clears header, count, CRC
// and loads the default start, ack and nak codes.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_frame_receiver_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [crc8fr_pkg::BYTE_W-1:0]      i_rx_byte,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic      [crc8fr_pkg::KIND_W-1:0]      o_event_kind,
    output logic      [crc8fr_pkg::BYTE_W-1:0]      o_frame_command,
    output logic      [crc8fr_pkg::BYTE_W-1:0]      o_payload_byte,
    output logic      [crc8fr_pkg::LEN_W-1:0]       o_payload_position,
    output logic      [crc8fr_pkg::LEN_W-1:0]       o_frame_length,
    input  wire logic                               i_cfg_we,
    input  wire logic [crc8fr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [crc8fr_pkg::BYTE_W-1:0]      i_cfg_data
);

    crc8fr_pkg::t_phase r_phase, n_phase;
    logic [crc8fr_pkg::BYTE_W-1:0] r_cmd, n_cmd;
    logic [crc8fr_pkg::LEN_W-1:0]  r_len, n_len;
    logic [crc8fr_pkg::LEN_W-1:0]  r_count, n_count;
    logic [crc8fr_pkg::BYTE_W-1:0] r_crc, n_crc;
    logic [crc8fr_pkg::BYTE_W-1:0] r_start_code, r_ack_code, r_nak_code;

    logic                          r_out_valid;
    crc8fr_pkg::t_event            r_kind, n_kind;
    logic [crc8fr_pkg::BYTE_W-1:0] r_out_cmd, n_out_cmd;
    logic [crc8fr_pkg::BYTE_W-1:0] r_out_data, n_out_data;
    logic [crc8fr_pkg::LEN_W-1:0]  r_out_pos, n_out_pos;
    logic [crc8fr_pkg::LEN_W-1:0]  r_out_len, n_out_len;
    logic                          n_has_result;

    logic                          accept;
    logic [crc8fr_pkg::BYTE_W-1:0] crc_next;
    logic [crc8fr_pkg::LEN_W-1:0]  count_inc;
    logic [crc8fr_pkg::LEN_W-1:0]  len_full;

    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    assign count_inc = r_count + crc8fr_pkg::LEN_W'(1);
    assign len_full  = {i_rx_byte, r_len[crc8fr_pkg::BYTE_W-1:0]};

    crc8fr_crc u_crc (
        .i_crc  (r_crc),
        .i_data (i_rx_byte),
        .o_crc  (crc_next)
    );

    // next parse state
    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_count = r_count;
        n_crc   = r_crc;
        unique case (r_phase)
            crc8fr_pkg::PH_CMD: begin
                n_cmd   = i_rx_byte;
                n_phase = crc8fr_pkg::PH_LEN_LO;
            end
            crc8fr_pkg::PH_LEN_LO: begin
                n_len   = {{crc8fr_pkg::BYTE_W{1'b0}}, i_rx_byte};
                n_phase = crc8fr_pkg::PH_LEN_HI;
            end
            crc8fr_pkg::PH_LEN_HI: begin
                n_len   = len_full;
                n_count = '0;
                n_crc   = crc8fr_pkg::CRC_INIT;
                n_phase = (len_full != '0) ? crc8fr_pkg::PH_DATA : crc8fr_pkg::PH_CRC;
            end
            crc8fr_pkg::PH_DATA: begin
                n_crc   = crc_next;
                n_count = count_inc;
                if (count_inc >= r_len) begin
                    n_phase = crc8fr_pkg::PH_CRC;
                end
            end
            crc8fr_pkg::PH_CRC: begin
                n_phase = crc8fr_pkg::PH_IDLE;
            end
            default: begin
                n_phase = crc8fr_pkg::PH_IDLE;
                if (i_rx_byte != r_ack_code && i_rx_byte != r_nak_code &&
                    i_rx_byte == r_start_code) begin
                    n_crc   = crc8fr_pkg::CRC_INIT;
                    n_count = '0;
                    n_phase = crc8fr_pkg::PH_CMD;
                end
            end
        endcase
    end

    // result beat
    always_comb begin
        n_has_result = 1'b0;
        n_kind       = crc8fr_pkg::EV_ACK;
        n_out_cmd    = '0;
        n_out_data   = '0;
        n_out_pos    = '0;
        n_out_len    = '0;
        unique case (r_phase)
            crc8fr_pkg::PH_CMD, crc8fr_pkg::PH_LEN_LO, crc8fr_pkg::PH_LEN_HI: begin
                n_has_result = 1'b0;
            end
            crc8fr_pkg::PH_DATA: begin
                n_has_result = 1'b1;
                n_kind       = crc8fr_pkg::EV_DATA;
                n_out_cmd    = r_cmd;
                n_out_data   = i_rx_byte;
                n_out_pos    = r_count;
                n_out_len    = r_len;
            end
            crc8fr_pkg::PH_CRC: begin
                n_has_result = 1'b1;
                n_kind       = (i_rx_byte == r_crc) ? crc8fr_pkg::EV_GOOD
                                                    : crc8fr_pkg::EV_BAD;
                n_out_cmd    = r_cmd;
                n_out_len    = r_len;
            end
            default: begin
                if (i_rx_byte == r_ack_code) begin
                    n_has_result = 1'b1;
                    n_kind       = crc8fr_pkg::EV_ACK;
                end else if (i_rx_byte == r_nak_code) begin
                    n_has_result = 1'b1;
                    n_kind       = crc8fr_pkg::EV_NAK;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= crc8fr_pkg::PH_IDLE;
            r_cmd        <= '0;
            r_len        <= '0;
            r_count      <= '0;
            r_crc        <= crc8fr_pkg::CRC_INIT;
            r_start_code <= crc8fr_pkg::START_CODE_RST;
            r_ack_code   <= crc8fr_pkg::ACK_CODE_RST;
            r_nak_code   <= crc8fr_pkg::NAK_CODE_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_cmd   <= n_cmd;
                r_len   <= n_len;
                r_count <= n_count;
                r_crc   <= n_crc;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    crc8fr_pkg::CFG_START: r_start_code <= i_cfg_data;
                    crc8fr_pkg::CFG_ACK:   r_ack_code   <= i_cfg_data;
                    crc8fr_pkg::CFG_NAK:   r_nak_code   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (!o_stall) begin
                r_out_valid <= accept & n_has_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind     <= n_kind;
            r_out_cmd  <= n_out_cmd;
            r_out_data <= n_out_data;
            r_out_pos  <= n_out_pos;
            r_out_len  <= n_out_len;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_event_kind       = r_kind;
    assign o_frame_command    = r_out_cmd;
    assign o_payload_byte     = r_out_data;
    assign o_payload_position = r_out_pos;
    assign o_frame_length     = r_out_len;

endmodule

`default_nettype wire

>>> src/crc8fr_crc.sv
// ----------------------------------------------------------------------------
// crc8fr_crc
// One-byte CRC-8 update, MSB first, polynomial from the package.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8fr_crc (
    input  wire logic [crc8fr_pkg::BYTE_W-1:0] i_crc,
    input  wire logic [crc8fr_pkg::BYTE_W-1:0] i_data,
    output logic      [crc8fr_pkg::BYTE_W-1:0] o_crc
);

    always_comb begin
        logic [crc8fr_pkg::BYTE_W-1:0] c;
        c = i_crc ^ i_data;
        for (int i = 0; i < crc8fr_pkg::BYTE_W; i++) begin
            if (c[crc8fr_pkg::BYTE_W-1]) begin
                c = {c[crc8fr_pkg::BYTE_W-2:0], 1'b0} ^ crc8fr_pkg::CRC_POLY;
            end else begin
                c = {c[crc8fr_pkg::BYTE_W-2:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

`default_nettype wire
